FILE: rtl/core/box_blur_3x3_edge_aware_macros.svh
// Assertion macros used by the checker file of the 3x3 box blur.
// Needs nothing else; include by bare file name.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BB3_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("box blur assertion failed");

// Check a property on every rising edge, reset included.
`define BB3_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("box blur reset assertion failed");

`endif

FILE: rtl/core/bb3_pkg.sv
// Types, register indexes and the reciprocal table of the 3x3 box blur.
// No dependencies; used by the top level and the port checker.
package bb3_pkg;

  typedef logic [23:0]      px_t;
  typedef logic [2:0][11:0] sum3_t;
  typedef logic [3:0]       cnt_t;
  typedef logic [17:0]      recip_t;
  typedef logic             cfg_idx_t;

  typedef struct packed {
    px_t top;
    px_t mid;
    px_t bot;
  } col_t;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_item_t;

  localparam logic     CMD_PIXEL        = 1'b0;
  localparam logic     CMD_FLUSH        = 1'b1;
  localparam cfg_idx_t CFG_FRAME_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_FRAME_HEIGHT = 1'b1;

  localparam int RECIP_SHIFT = 18;

  // ceil(2^18 / (2*n)); exact quotient for numerators below 2^13
  function automatic recip_t recip(input cnt_t n);
    recip_t r;
    case (n)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      4'd9:    r = 18'd14564;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/bb3_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/box_blur_3x3_edge_aware.sv
// Edge-aware 3x3 box blur over a raster RGB stream, top level.
// Depends on bb3_pkg and bb3_ram (two line buffers).
//
// Use: send frame_width (index 0) and frame_height (index 1) on the cfg port
// while the block is idle; each write restarts the frame. Then send pixels
// (command 0) in raster order on in_valid/in_ready, then one flush item
// (command 1) per pixel of the last row. Results leave on out_valid/out_ready:
// output row r-1 comes while row r arrives, one column behind, and the last
// pixel of a row also yields its own column. frame_end marks the last output.
// Items do not overlap: in_ready is high only in idle and the sequencer walks
// read, sum and the two result slots of one item before it takes the next, a
// flush reading its window column by column through the one read port of each
// line buffer. A pixel may fill both result slots, a flush only the second.
// Pixels sent while the last row drains and flushes sent before
// it are dropped. Output sits in one register; a new item is still accepted
// while it waits, and a stalled receiver holds the sequencer at its result
// slot. Reset sets 1024x768, clears counters; line buffers are not cleared.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bb3_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bb3_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  bb3_pkg::cfg_idx_t cfg_index,
  input  logic [11:0]       cfg_wdata
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_EMIT0 = 3'd3;
  localparam logic [2:0] S_EMIT1 = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    step_r, step_nxt;
  logic          fl_vld_r, fl_vld_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;
  logic [CW-1:0] drain_r, drain_nxt;
  logic [10:0]   fw_r, fw_nxt;
  logic [11:0]   fh_r, fh_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;
  col_t          win_r [2];
  col_t          win_nxt [2];
  px_t           pix_r, pix_nxt;
  sum3_t         job_sum_r [2];
  sum3_t         job_sum_nxt [2];
  cnt_t          job_n_r [2];
  cnt_t          job_n_nxt [2];
  logic [1:0]    job_v_r, job_v_nxt;
  logic          job_fe_r, job_fe_nxt;

  logic [CW:0]   eff_w;
  logic [CW-1:0] w_last;
  logic [11:0]   eff_h;
  logic          draining;

  logic          mem_re, mem_we;
  logic [CW-1:0] mem_raddr;
  px_t           upper_q, middle_q;

  col_t          cur;
  logic          top_on, c1, c2;
  sum3_t         sum_a, sum_b;
  cnt_t          n_a, n_b;

  logic          sel;
  logic          out_free;
  logic [2:0][7:0] div_q;

  function automatic sum3_t col_sum(input col_t cl, input logic use_top);
    sum3_t s;
    for (int k = 0; k < 3; k++) begin
      s[k] = 12'(cl.mid[8*k +: 8]) + 12'(cl.bot[8*k +: 8])
           + (use_top ? 12'(cl.top[8*k +: 8]) : 12'd0);
    end
    return s;
  endfunction

  function automatic sum3_t add_sum(input sum3_t a, input sum3_t b);
    sum3_t s;
    for (int k = 0; k < 3; k++) begin
      s[k] = a[k] + b[k];
    end
    return s;
  endfunction

  always_comb begin
    if (fw_r == 11'd0) begin
      eff_w = (CW+1)'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(fw_r);
    end
    w_last   = CW'(eff_w - (CW+1)'(1));
    eff_h    = (fh_r == 12'd0) ? 12'd1 : fh_r;
    draining = row_r >= eff_h;
  end

  bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (mem_we),
    .waddr (col_r),
    .wdata (middle_q),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (upper_q)
  );

  bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (mem_we),
    .waddr (col_r),
    .wdata (pix_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (middle_q)
  );

  // window sums for the pixel path
  always_comb begin
    cur.top = upper_q;
    cur.mid = middle_q;
    cur.bot = pix_r;
    top_on  = row_r >= 12'd2;
    c1      = 32'(col_r) >= 1;
    c2      = 32'(col_r) >= 2;
    sum_a   = add_sum(add_sum(col_sum(cur, top_on), col_sum(win_r[0], top_on)),
                      c2 ? col_sum(win_r[1], top_on) : '0);
    sum_b   = add_sum(col_sum(cur, top_on), c1 ? col_sum(win_r[0], top_on) : '0);
    n_a     = top_on ? (c2 ? 4'd9 : 4'd6) : (c2 ? 4'd6 : 4'd4);
    n_b     = top_on ? (c1 ? 4'd6 : 4'd3) : (c1 ? 4'd4 : 4'd2);
  end

  // rounded mean: (2*sum + n) / (2*n) by reciprocal
  always_comb begin
    logic [12:0] num;
    logic [30:0] prod;
    sel = state_r == S_EMIT1;
    for (int k = 0; k < 3; k++) begin
      num      = {job_sum_r[sel][k], 1'b0} + 13'(job_n_r[sel]);
      prod     = 31'(num) * 31'(recip(job_n_r[sel]));
      div_q[k] = prod[RECIP_SHIFT +: 8];
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    fl_vld_nxt    = fl_vld_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    drain_nxt     = drain_r;
    fw_nxt        = fw_r;
    fh_nxt        = fh_r;
    win_nxt       = win_r;
    pix_nxt       = pix_r;
    job_sum_nxt   = job_sum_r;
    job_n_nxt     = job_n_r;
    job_v_nxt     = job_v_r;
    job_fe_nxt    = job_fe_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = col_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_PIXEL) begin
            if (!draining) begin
              mem_re    = 1'b1;
              pix_nxt   = {in_data.red_in, in_data.green_in, in_data.blue_in};
              state_nxt = S_PIX;
            end
          end else if (draining) begin
            job_sum_nxt[1] = '0;
            job_n_nxt[1]   = '0;
            step_nxt       = 2'd0;
            fl_vld_nxt     = 1'b0;
            state_nxt      = S_FLUSH;
          end
        end
      end
      S_PIX: begin
        mem_we         = 1'b1;
        win_nxt[1]     = win_r[0];
        win_nxt[0]     = cur;
        job_sum_nxt[0] = sum_a;
        job_sum_nxt[1] = sum_b;
        job_n_nxt[0]   = n_a;
        job_n_nxt[1]   = n_b;
        job_v_nxt[0]   = (row_r != 12'd0) && c1;
        job_v_nxt[1]   = (row_r != 12'd0) && (col_r == w_last);
        job_fe_nxt     = 1'b0;
        if (col_r == w_last) begin
          col_nxt = '0;
          row_nxt = (row_r + 12'd1 >= eff_h) ? eff_h : row_r + 12'd1;
        end else begin
          col_nxt = col_r + CW'(1);
        end
        state_nxt = S_EMIT0;
      end
      S_FLUSH: begin
        if (fl_vld_r) begin
          job_sum_nxt[1] = add_sum(job_sum_r[1],
                                   col_sum('{top: upper_q, mid: middle_q, bot: '0},
                                           eff_h >= 12'd2));
          job_n_nxt[1]   = job_n_r[1] + ((eff_h >= 12'd2) ? 4'd2 : 4'd1);
        end
        if (step_r != 2'd3) begin
          mem_re     = 1'b1;
          mem_raddr  = CW'(32'(drain_r) + 32'(step_r) - 1);
          fl_vld_nxt = !((step_r == 2'd0) && (drain_r == '0)) &&
                       !((step_r == 2'd2) && (drain_r == w_last));
          step_nxt   = step_r + 2'd1;
        end else begin
          job_v_nxt  = 2'b10;
          job_fe_nxt = drain_r == w_last;
          if (drain_r == w_last) begin
            col_nxt    = '0;
            row_nxt    = '0;
            drain_nxt  = '0;
            win_nxt[0] = '0;
            win_nxt[1] = '0;
          end else begin
            drain_nxt = drain_r + CW'(1);
          end
          state_nxt = S_EMIT1;
        end
      end
      S_EMIT0, S_EMIT1: begin
        if (!job_v_r[sel] || out_free) begin
          if (job_v_r[sel]) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{red_out: div_q[2], green_out: div_q[1], blue_out: div_q[0],
                              frame_end: sel && job_fe_r};
          end
          state_nxt = sel ? S_IDLE : S_EMIT1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_nxt = cfg_wdata[10:0];
        CFG_FRAME_HEIGHT: fh_nxt = cfg_wdata;
        default:          fw_nxt = fw_r;
      endcase
      col_nxt    = '0;
      row_nxt    = '0;
      drain_nxt  = '0;
      win_nxt[0] = '0;
      win_nxt[1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 2'd0;
      fl_vld_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      drain_r     <= '0;
      fw_r        <= 11'd1024;
      fh_r        <= 12'd768;
      out_valid_r <= 1'b0;
      job_v_r     <= 2'b00;
      win_r[0]    <= '0;
      win_r[1]    <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fl_vld_r    <= fl_vld_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      drain_r     <= drain_nxt;
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      out_valid_r <= out_valid_nxt;
      job_v_r     <= job_v_nxt;
      win_r       <= win_nxt;
    end
    pix_r      <= pix_nxt;
    job_sum_r  <= job_sum_nxt;
    job_n_r    <= job_n_nxt;
    job_fe_r   <= job_fe_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/bb3_checker.sv
// Port-level checks of the 3x3 box blur, bound to its top level.
// Depends on bb3_pkg and box_blur_3x3_edge_aware_macros.svh.
`include "box_blur_3x3_edge_aware_macros.svh"

module bb3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bb3_pkg::out_item_t out_data
);
  import bb3_pkg::*;

  `BB3_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)
  `BB3_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `BB3_ASSERT(a_idle_hold, clk, rst_n, in_ready && !in_valid |=> in_ready)
  `BB3_ASSERT(a_load_while_busy, clk, rst_n, $rose(out_valid) |-> !$past(in_ready))

endmodule

bind box_blur_3x3_edge_aware bb3_checker u_bb3_checker (.*);
